>>> rtl/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// shared constants, state encoding and controller/datapath interface types
// ----------------------------------------------------------------------------
package gps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int COORD_W    = 10;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int CROSS_W    = 2 * DIFF_W;
    localparam int THR_W      = 16;
    localparam int LIM_W      = THR_W + COORD_W;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_DRAIN,
        S_TEST,
        S_EMIT_FIRST,
        S_EMIT_VTX,
        S_EMIT_LAST
    } t_state;

    typedef enum logic {
        OUT_POINT,
        OUT_VTX
    } t_out_sel;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     first;
        logic     drop;
        logic     store;
        logic     scan_rd;
        logic     take_vtx;
        logic     load_out;
        t_out_sel out_sel;
        logic     out_eor;
        logic     clear_run;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic last;
        logic has_scan;
        logic scan_end;
        logic pipe_busy;
        logic hit;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/gps_ctrl.sv
// ----------------------------------------------------------------------------
// gps_ctrl
// sequencer for one point: decide, scan the window, test, emit words
// ----------------------------------------------------------------------------
module gps_ctrl
    import gps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // held off through reset as well
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_sel = OUT_POINT;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_sts.cnt_zero) begin
                    o_cmd.first = 1'b1;
                    n_state     = S_EMIT_FIRST;
                end else if (i_sts.cnt_full) begin
                    o_cmd.drop = 1'b1;
                    n_state    = i_sts.last ? S_EMIT_LAST : S_IDLE;
                end else begin
                    o_cmd.store = 1'b1;
                    if (i_sts.has_scan) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = i_sts.last ? S_EMIT_LAST : S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.hit) begin
                    o_cmd.take_vtx = 1'b1;
                    n_state        = S_EMIT_VTX;
                end else begin
                    n_state = i_sts.last ? S_EMIT_LAST : S_IDLE;
                end
            end
            S_EMIT_FIRST: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = OUT_POINT;
                    n_state        = i_sts.last ? S_EMIT_LAST : S_IDLE;
                end
            end
            S_EMIT_VTX: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = OUT_VTX;
                    n_state        = i_sts.last ? S_EMIT_LAST : S_IDLE;
                end
            end
            S_EMIT_LAST: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.out_sel   = OUT_POINT;
                    o_cmd.out_eor   = 1'b1;
                    o_cmd.clear_run = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/gps_dp.sv
// ----------------------------------------------------------------------------
// gps_dp
// point store, run state, three-stage cross product scan and output register
// ----------------------------------------------------------------------------
module gps_dp
    import gps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_is_last,
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_data,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [COORD_W-1:0] o_vertex_x,
    output logic [COORD_W-1:0] o_vertex_y,
    output logic               o_end_of_run,
    output logic               o_overflow
);

    // point store, x in the upper half
    logic [2*COORD_W-1:0] mem [MAX_POINTS];

    // configuration and run state
    logic [THR_W-1:0]   r_thr;
    logic [COORD_W-1:0] r_ax;
    logic [COORD_W-1:0] r_ay;
    logic [ADDR_W-1:0]  r_win;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_dropped;

    // current point
    logic [COORD_W-1:0]       r_px;
    logic [COORD_W-1:0]       r_py;
    logic                     r_last;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [COORD_W-1:0]       r_adx;
    logic [LIM_W-1:0]         r_lim;
    logic [ADDR_W-1:0]        r_cur_i;

    // scan pipeline
    logic [ADDR_W-1:0]         r_scan_j;
    logic                      r_v1;
    logic [ADDR_W-1:0]         r_j1;
    logic [2*COORD_W-1:0]      r_rd;
    logic                      r_v2;
    logic [ADDR_W-1:0]         r_j2;
    logic [2*COORD_W-1:0]      r_rd2;
    logic signed [CROSS_W-1:0] r_p1;
    logic signed [CROSS_W-1:0] r_p2;
    logic [CROSS_W-1:0]        r_best;
    logic [ADDR_W-1:0]         r_cand;
    logic [2*COORD_W-1:0]      r_best_pt;

    // output register
    logic               r_ov;
    logic [COORD_W-1:0] r_ox;
    logic [COORD_W-1:0] r_oy;
    logic               r_oeor;
    logic               r_oovf;

    logic signed [DIFF_W-1:0]  w_dx_in;
    logic signed [DIFF_W-1:0]  w_dy_in;
    logic signed [DIFF_W-1:0]  w_dyj;
    logic signed [DIFF_W-1:0]  w_dxj;
    logic signed [CROSS_W-1:0] w_c;
    logic [CROSS_W-1:0]        w_abs;
    logic [CNT_W-1:0]          w_win_nx;
    logic                      w_out_free;

    assign w_dx_in = $signed({1'b0, i_point_x}) - $signed({1'b0, r_ax});
    assign w_dy_in = $signed({1'b0, i_point_y}) - $signed({1'b0, r_ay});

    assign w_dyj = $signed({1'b0, r_rd[COORD_W-1:0]}) - $signed({1'b0, r_ay});
    assign w_dxj = $signed({1'b0, r_rd[2*COORD_W-1:COORD_W]}) - $signed({1'b0, r_ax});

    assign w_c   = r_p1 - r_p2;
    assign w_abs = w_c[CROSS_W-1] ? CROSS_W'(-w_c) : CROSS_W'(w_c);

    assign w_win_nx   = CNT_W'(r_win) + CNT_W'(1);
    assign w_out_free = !r_ov || !i_stall;

    assign o_sts.cnt_zero  = (r_cnt == '0);
    assign o_sts.cnt_full  = (r_cnt == CNT_W'(MAX_POINTS));
    assign o_sts.last      = r_last;
    assign o_sts.has_scan  = (r_dx != '0) && (w_win_nx < r_cnt);
    assign o_sts.scan_end  = ((CNT_W'(r_scan_j) + CNT_W'(1)) == CNT_W'(r_cur_i));
    assign o_sts.pipe_busy = r_v1 || r_v2;
    assign o_sts.hit       = ({r_best, 4'b0000} > (CROSS_W + 4)'(r_lim));
    assign o_sts.out_free  = w_out_free;

    // store write and scan read
    always_ff @(posedge i_clk) begin
        if (i_cmd.first || i_cmd.store) begin
            mem[r_cnt[ADDR_W-1:0]] <= {r_px, r_py};
        end
        if (i_cmd.scan_rd) begin
            r_rd <= mem[r_scan_j];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THR_RESET;
            r_ax      <= '0;
            r_ay      <= '0;
            r_win     <= '0;
            r_cnt     <= '0;
            r_dropped <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_v1 <= i_cmd.scan_rd;
            r_v2 <= r_v1;
            if (i_cmd.first) begin
                r_ax  <= r_px;
                r_ay  <= r_py;
                r_win <= '0;
                r_cnt <= CNT_W'(1);
            end
            if (i_cmd.store) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.drop) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.take_vtx) begin
                r_ax  <= r_best_pt[2*COORD_W-1:COORD_W];
                r_ay  <= r_best_pt[COORD_W-1:0];
                r_win <= r_cand;
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.clear_run) begin
                r_ax      <= '0;
                r_ay      <= '0;
                r_win     <= '0;
                r_cnt     <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px   <= i_point_x;
            r_py   <= i_point_y;
            r_last <= i_is_last;
            r_dx   <= w_dx_in;
            r_dy   <= w_dy_in;
            r_adx  <= w_dx_in[DIFF_W-1] ? COORD_W'(-w_dx_in) : COORD_W'(w_dx_in);
        end
        if (i_cmd.store) begin
            r_lim    <= LIM_W'(r_thr * r_adx);
            r_cur_i  <= r_cnt[ADDR_W-1:0];
            r_scan_j <= w_win_nx[ADDR_W-1:0];
            r_best   <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan_j <= r_scan_j + ADDR_W'(1);
        end
        r_j1  <= r_scan_j;
        // stage two: the two products of the cross term
        r_j2  <= r_j1;
        r_rd2 <= r_rd;
        r_p1  <= w_dyj * r_dx;
        r_p2  <= w_dxj * r_dy;
        // stage three: running maximum, first index wins a tie
        if (r_v2 && (w_abs > r_best)) begin
            r_best    <= w_abs;
            r_cand    <= r_j2;
            r_best_pt <= r_rd2;
        end
        if (i_cmd.load_out) begin
            r_oeor <= i_cmd.out_eor;
            r_oovf <= r_dropped;
            unique case (i_cmd.out_sel)
                OUT_POINT: begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                end
                OUT_VTX: begin
                    r_ox <= r_best_pt[2*COORD_W-1:COORD_W];
                    r_oy <= r_best_pt[COORD_W-1:0];
                end
                default: begin
                    r_ox <= r_px;
                    r_oy <= r_py;
                end
            endcase
        end
    end

    assign o_valid      = r_ov;
    assign o_vertex_x   = r_ox;
    assign o_vertex_y   = r_oy;
    assign o_end_of_run = r_oeor;
    assign o_overflow   = r_oovf;

endmodule

>>> rtl/greedy_polyline_simplifier.sv
// ----------------------------------------------------------------------------
// greedy_polyline_simplifier
// greedy vertex reduction of an outline streamed one point per word
// ----------------------------------------------------------------------------
// Points of an outline enter one per word, the final one flagged by
// is_last. The first point is sent out at once and becomes the anchor.
// Every later point is written to a 1024-entry point store, and the
// stored points between the anchor and it are read back one per cycle
// through a three-stage pipeline (store read, two 11x11 products,
// absolute cross term and running maximum). If sixteen times the largest
// cross term exceeds error_threshold times |dx|, the first point holding
// it is sent out and becomes the new anchor; a flagged point is then sent
// out with end_of_run set. A point with the same x as the anchor gives no
// vertex. Once the store is full, further points are dropped and the
// overflow bit is set on the final vertex. A word occupies the block until
// its scan, test and output are through; no new point is taken till then.
// The scan covers the stored points strictly between the anchor and it, is
// bound by the single read port of the point store, and is skipped when
// there is nothing to scan or the point shares the anchor's x. Each result
// word passes the output register, which holds a finished word while the
// next point is taken. The input is stalled during reset. The store needs
// no clearing after reset.
// ----------------------------------------------------------------------------
module greedy_polyline_simplifier
    import gps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // point words in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_is_last,
    // vertex words out
    output logic               o_valid,
    input  logic               i_stall,
    output logic [COORD_W-1:0] o_vertex_x,
    output logic [COORD_W-1:0] o_vertex_y,
    output logic               o_end_of_run,
    output logic               o_overflow,
    // error threshold register, unsigned 12.4 pixels
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: one point word at a time
    gps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // store, scan pipeline and output register
    gps_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_is_last    (i_is_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_vertex_x   (o_vertex_x),
        .o_vertex_y   (o_vertex_y),
        .o_end_of_run (o_end_of_run),
        .o_overflow   (o_overflow)
    );

endmodule

>>> bench/gps_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_vertex_checker
// predicts the kept vertices of each outline and compares them on the way out
// ----------------------------------------------------------------------------
// Watches the point channel, the vertex channel and the threshold port.
// Every accepted point word goes through a bit-exact copy of the greedy
// simplification; the vertex words it yields queue up in order and are
// compared with the vertex words the block hands over.
// ----------------------------------------------------------------------------
module gps_vertex_checker
    import gps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pt_valid,
    input  logic               i_pt_stall,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic               i_is_last,
    input  logic               i_vtx_valid,
    input  logic               i_vtx_stall,
    input  logic [COORD_W-1:0] i_vertex_x,
    input  logic [COORD_W-1:0] i_vertex_y,
    input  logic               i_end_of_run,
    input  logic               i_overflow,
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               eor;
        logic               ovf;
    } t_vertex;

    logic [COORD_W-1:0] pt_x [MAX_POINTS];
    logic [COORD_W-1:0] pt_y [MAX_POINTS];
    logic [COORD_W-1:0] anc_x;
    logic [COORD_W-1:0] anc_y;
    int                 win_start;
    int                 run_len;
    logic               dropped;
    logic [THR_W-1:0]   thr;
    t_vertex            vertex_q [$];
    t_vertex            want;
    int                 fails;

    function automatic void emit(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 input logic eor);
        t_vertex v;
        v.x      = x;
        v.y      = y;
        v.eor    = eor;
        v.ovf    = dropped;
        vertex_q = {vertex_q, v};
    endfunction

    function automatic void clear_run();
        anc_x     = '0;
        anc_y     = '0;
        win_start = 0;
        run_len   = 0;
        dropped   = 1'b0;
    endfunction

    // greedy step for one point word
    function automatic void track_point(input logic [COORD_W-1:0] px,
                                        input logic [COORD_W-1:0] py, input logic last);
        longint dx;
        longint dy;
        longint adx;
        longint c;
        longint best;
        int     cand;
        int     j;
        if (run_len == 0) begin
            pt_x[0]   = px;
            pt_y[0]   = py;
            anc_x     = px;
            anc_y     = py;
            win_start = 0;
            run_len   = 1;
            emit(px, py, 1'b0);
        end else if (run_len >= MAX_POINTS) begin
            // store full, point dropped
            dropped = 1'b1;
        end else begin
            pt_x[run_len] = px;
            pt_y[run_len] = py;
            dx   = longint'(px) - longint'(anc_x);
            dy   = longint'(py) - longint'(anc_y);
            adx  = (dx < 0) ? -dx : dx;
            best = 0;
            cand = win_start;
            if (dx != 0) begin
                for (j = win_start + 1; j <= run_len; j++) begin
                    c = (longint'(pt_y[j]) - longint'(anc_y)) * dx
                      - (longint'(pt_x[j]) - longint'(anc_x)) * dy;
                    if (c < 0)
                        c = -c;
                    if (c > best) begin
                        best = c;
                        cand = j;
                    end
                end
                if (best * 16 > longint'(thr) * adx) begin
                    anc_x     = pt_x[cand];
                    anc_y     = pt_y[cand];
                    win_start = cand;
                    emit(anc_x, anc_y, 1'b0);
                end
            end
            run_len++;
        end
        if (last) begin
            emit(px, py, 1'b1);
            clear_run();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_run();
            thr = THR_RESET;
            vertex_q.delete();
        end else begin
            if (i_vtx_valid && !i_vtx_stall) begin
                if (vertex_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected vertex word x=%0d y=%0d end=%0b ovf=%0b",
                             $time, i_vertex_x, i_vertex_y, i_end_of_run, i_overflow);
                end else begin
                    want = vertex_q.pop_front();
                    if (want.x !== i_vertex_x || want.y !== i_vertex_y ||
                        want.eor !== i_end_of_run || want.ovf !== i_overflow) begin
                        fails++;
                        $display({"%0t: vertex mismatch, expected x=%0d y=%0d end=%0b ",
                                  "ovf=%0b, actual x=%0d y=%0d end=%0b ovf=%0b"},
                                 $time, want.x, want.y, want.eor, want.ovf,
                                 i_vertex_x, i_vertex_y, i_end_of_run, i_overflow);
                    end
                end
            end
            if (i_cfg_we)
                thr = i_cfg_data;
            if (i_pt_valid && !i_pt_stall)
                track_point(i_point_x, i_point_y, i_is_last);
        end
        o_fail_count <= fails;
        o_pending    <= vertex_q.size();
    end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the greedy polyline simplifier
// ----------------------------------------------------------------------------
// Streams outlines of points into the block under several error thresholds:
// a short directed set, then random outlines, mostly well-formed with some
// noise. Both channels idle at random, one phase runs without any idling
// and one holds the vertex channel off for a long stretch. A checker beside
// the block predicts and compares every vertex word.
// ----------------------------------------------------------------------------
module tb_top;
    import gps_pkg::*;

    typedef enum int {
        PH_DIRECTED,
        PH_WIDE,
        PH_PRESSURE,
        PH_CALM,
        PH_MIXED
    } t_phase;

    localparam int SETTLE_CYCLES = 1100;            // worst scan plus margin
    localparam int HOLD_CYCLES   = 3000;            // long receiver hold-off
    localparam int QUIET_LIMIT   = 20000;           // cycles with no word moving
    localparam int IDLE_PCT      = 26;
    localparam int PHASE_POINTS  = 113;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               o_stall;
    logic [COORD_W-1:0] i_point_x  = '0;
    logic [COORD_W-1:0] i_point_y  = '0;
    logic               i_is_last  = 1'b0;
    logic               o_valid;
    logic               i_stall    = 1'b0;
    logic [COORD_W-1:0] o_vertex_x;
    logic [COORD_W-1:0] o_vertex_y;
    logic               o_end_of_run;
    logic               o_overflow;
    logic               i_cfg_we   = 1'b0;
    logic [THR_W-1:0]   i_cfg_data = '0;

    t_phase phase    = PH_DIRECTED;
    bit     held_off = 1'b0;
    int     fail_count;
    int     pending;
    int     quiet    = 0;

    always #5 i_clk = ~i_clk;

    greedy_polyline_simplifier i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_is_last    (i_is_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_vertex_x   (o_vertex_x),
        .o_vertex_y   (o_vertex_y),
        .o_end_of_run (o_end_of_run),
        .o_overflow   (o_overflow),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    gps_vertex_checker u_vertex_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt_valid   (i_valid),
        .i_pt_stall   (o_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_is_last    (i_is_last),
        .i_vtx_valid  (o_valid),
        .i_vtx_stall  (i_stall),
        .i_vertex_x   (o_vertex_x),
        .i_vertex_y   (o_vertex_y),
        .i_end_of_run (o_end_of_run),
        .i_overflow   (o_overflow),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // offer one point word, with random gaps ahead of it except in the calm
    // phase; returns at the edge that takes the word, valid still high
    task automatic send_word(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic last);
        if (phase != PH_CALM) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_is_last <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // stop offering, let every predicted vertex come out, then allow for a
    // point that is still being scanned but yields no vertex
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // threshold changes only while the block sits idle
    task automatic set_threshold(input logic [THR_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one outline: tidy ones have rising x and a wandering y, long tidy ones
    // stay close to a line so the scan window grows; noisy ones jump about,
    // repeat x and run backwards
    task automatic send_outline(input int len, input bit tidy);
        int x;
        int y;
        int k;
        int step_max;
        int wig;
        step_max = (len > 40) ? 3 : 24;
        wig      = (len > 40) ? 3 : 60;
        x = $urandom_range(0, 300);
        y = $urandom_range(0, 1023);
        for (k = 0; k < len; k++) begin
            if (tidy) begin
                if (k > 0)
                    x = x + int'($urandom_range(1, step_max));
                if (x > 1023)
                    x = 1023;
                if ($urandom_range(0, 9) == 0)
                    y = $urandom_range(0, 1023);
                else
                    y = y + int'($urandom_range(0, 2 * wig)) - wig;
            end else begin
                if ($urandom_range(0, 3) != 0)
                    x = $urandom_range(0, 1023);
                y = $urandom_range(0, 1023);
            end
            if (y < 0)
                y = 0;
            if (y > 1023)
                y = 1023;
            send_word(COORD_W'(x), COORD_W'(y), k == len - 1);
        end
    endtask

    // mostly short outlines, now and then a long one; the last outline is
    // cut to the budget
    task automatic send_random(input int n_points);
        int sent;
        int len;
        sent = 0;
        while (sent < n_points) begin
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(100, 250);
            else
                len = $urandom_range(1, 30);
            if (len > n_points - sent)
                len = n_points - sent;
            send_outline(len, $urandom_range(0, 4) != 0);
            sent += len;
        end
    endtask

    // vertex side: random stalls, one long hold-off in the pressure phase so
    // the output register backs up through the sequencer into the point channel
    initial begin : vertex_sink
        forever begin
            @(posedge i_clk);
            if (phase == PH_PRESSURE && !held_off) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held_off = 1'b1;
            end else begin
                i_stall <= (phase != PH_CALM) && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ends the run if no word moves on either channel for too long
    initial begin : watchdog
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed outlines at the reset threshold of one pixel
        // single point outlines at both corners, each sent out twice
        send_word(10'd0, 10'd0, 1'b1);
        send_word(10'd1023, 10'd1023, 1'b1);
        // vertical run, no vertex kept
        send_word(10'd5, 10'd100, 1'b0);
        send_word(10'd5, 10'd900, 1'b0);
        send_word(10'd5, 10'd0, 1'b1);
        // sharp peak, vertex then the last point
        send_word(10'd0, 10'd0, 1'b0);
        send_word(10'd10, 10'd500, 1'b0);
        send_word(10'd20, 10'd0, 1'b1);
        // straight line, nothing kept in between
        send_word(10'd0, 10'd0, 1'b0);
        send_word(10'd100, 10'd100, 1'b0);
        send_word(10'd200, 10'd200, 1'b1);
        // extremes with x running backwards
        send_word(10'd0, 10'd1023, 1'b0);
        send_word(10'd1023, 10'd0, 1'b0);
        send_word(10'd512, 10'd1023, 1'b0);
        send_word(10'd1023, 10'd1023, 1'b1);

        // widest threshold, long windows
        set_threshold('1);
        phase = PH_WIDE;
        send_random(PHASE_POINTS);

        set_threshold(THR_W'($urandom_range(1, 64)));
        phase = PH_PRESSURE;
        send_random(PHASE_POINTS);

        set_threshold(THR_W'($urandom_range(0, 65535)));
        phase = PH_CALM;
        send_random(PHASE_POINTS);

        set_threshold(THR_W'($urandom_range(8, 400)));
        phase = PH_MIXED;
        send_random(PHASE_POINTS);

        set_threshold(THR_W'($urandom_range(1, 32)));
        send_random(PHASE_POINTS);

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/gps_pkg.sv
rtl/gps_ctrl.sv
rtl/gps_dp.sv
rtl/greedy_polyline_simplifier.sv
bench/gps_vertex_checker.sv
bench/tb_top.sv
